>>> design/snt_pkg.sv
// ----------------------------------------------------------------------------
// snt_pkg
// Shared constants, codes and types for the statement nesting tracker.
// ----------------------------------------------------------------------------
package snt_pkg;

  localparam int NEST_DEPTH = 20;
  localparam int DEPTH_W    = $clog2(NEST_DEPTH + 1);
  localparam int IDX_W      = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int OPEN_W     = 5;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LANGLE = 8'h3C;
  localparam logic [7:0] CH_RANGLE = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;

  typedef enum logic [1:0] {
    KIND_PROC = 2'd0,
    KIND_STR  = 2'd1,
    KIND_HEX  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_STR  = 2'd1,
    ESC_TOP  = 2'd2
  } esc_t;

  typedef struct packed {
    logic  push;
    kind_t kind;
  } stack_op_t;

  typedef struct packed {
    logic              keep;
    logic              done;
    logic              err;
    logic [OPEN_W-1:0] open_depth;
  } result_t;

endpackage

>>> design/snt_stack.sv
// ----------------------------------------------------------------------------
// snt_stack
// Bracket stack storage: entry registers, depth register and top-of-stack read.
// ----------------------------------------------------------------------------
module snt_stack import snt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  stack_op_t          op,
  input  logic [DEPTH_W-1:0] depth_nxt,
  output logic [DEPTH_W-1:0] depth,
  output kind_t              top_kind
);

  kind_t              entries_r [NEST_DEPTH];
  logic [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] depth_m1;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   top_idx;

  assign depth_m1 = depth_r - DEPTH_W'(1);
  assign top_idx  = depth_m1[IDX_W-1:0];
  assign wr_idx   = depth_r[IDX_W-1:0];
  assign top_kind = entries_r[top_idx];
  assign depth    = depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (en) begin
      depth_r <= depth_nxt;
    end
  end

  // entries are only read below the depth, so no reset needed
  always_ff @(posedge clk) begin
    if (en && op.push) begin
      entries_r[wr_idx] <= op.kind;
    end
  end

endmodule

>>> design/snt_step.sv
// ----------------------------------------------------------------------------
// snt_step
// Per-character decision: keep/done/error flags, stack operation, next depth, next escape.
// ----------------------------------------------------------------------------
module snt_step import snt_pkg::*; (
  input  logic [7:0]         ch,
  input  logic [DEPTH_W-1:0] depth,
  input  kind_t              top_kind,
  input  esc_t               esc,
  output stack_op_t          op,
  output logic [DEPTH_W-1:0] depth_nxt,
  output esc_t               esc_nxt,
  output result_t            res
);

  logic  keep;
  logic  done;
  logic  err;
  logic  push_req;
  logic  pop;
  logic  full;
  logic  is_opener;
  kind_t open_kind;
  kind_t push_kind;
  esc_t  esc_sel;

  always_comb begin
    is_opener = 1'b1;
    open_kind = KIND_PROC;
    case (ch)
      CH_LBRACE: open_kind = KIND_PROC;
      CH_LPAREN: open_kind = KIND_STR;
      CH_LANGLE: open_kind = KIND_HEX;
      default:   is_opener = 1'b0;
    endcase
  end

  always_comb begin
    keep      = 1'b1;
    done      = 1'b0;
    push_req  = 1'b0;
    pop       = 1'b0;
    push_kind = KIND_PROC;
    esc_sel   = ESC_NONE;
    case (esc)
      ESC_STR: begin
      end
      ESC_TOP: begin
        if (ch == CH_NL && depth == '0) begin
          keep = 1'b0;
          done = 1'b1;
        end
      end
      default: begin
        if (depth != '0) begin
          case (top_kind)
            KIND_PROC: begin
              if (ch == CH_RBRACE) begin
                pop = 1'b1;
              end else if (is_opener) begin
                push_req  = 1'b1;
                push_kind = open_kind;
              end
            end
            KIND_STR: begin
              if (ch == CH_RPAREN) begin
                pop = 1'b1;
              end else if (ch == CH_LPAREN) begin
                push_req  = 1'b1;
                push_kind = KIND_STR;
              end else if (ch == CH_BSLASH) begin
                esc_sel = ESC_STR;
              end
            end
            default: begin
              if (ch == CH_RANGLE) pop = 1'b1;
            end
          endcase
        end else begin
          if (is_opener) begin
            push_req  = 1'b1;
            push_kind = open_kind;
          end else if (ch == CH_BSLASH) begin
            esc_sel = ESC_TOP;
          end else if (ch == CH_NL) begin
            keep = 1'b0;
            done = 1'b1;
          end
        end
      end
    endcase
  end

  assign full    = (depth == DEPTH_W'(NEST_DEPTH));
  assign err     = push_req && full;
  assign op.push = push_req && !full;
  assign op.kind = push_kind;
  assign esc_nxt = err ? ESC_NONE : esc_sel;

  always_comb begin
    if (err) begin
      depth_nxt = '0;
    end else if (op.push) begin
      depth_nxt = depth + DEPTH_W'(1);
    end else if (pop) begin
      depth_nxt = depth - DEPTH_W'(1);
    end else begin
      depth_nxt = depth;
    end
  end

  assign res.keep       = keep && !err;
  assign res.done       = done && !err;
  assign res.err        = err;
  assign res.open_depth = OPEN_W'(depth_nxt);

endmodule

>>> design/statement_nesting_tracker.sv
// ----------------------------------------------------------------------------
// statement_nesting_tracker
// Tracks bracket nesting of a character stream and marks statement ends.
//
// Characters enter on in_valid/in_stall, one item per character; results
// leave on out_valid/out_stall, one item per character, in order.
// An item is taken into an input register, evaluated against the bracket
// stack and written to the result register together with the stack update;
// the out_ ports are driven from the result register.
// Throughput is one character per cycle while out_stall is low; the stack
// update (push or pop of the top entry, or a clear of the whole stack)
// carries each item's dependence on the one before.
// When out_stall is high with a result waiting, the result register holds,
// the input register holds one more item and in_stall rises once it is full.
// Reset (rst_n low, synchronous) empties both registers, sets the open
// bracket count to zero and clears any pending escape; stack entries are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module statement_nesting_tracker import snt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_char_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_keep_char,
  output logic              out_statement_done,
  output logic              out_nesting_error,
  output logic [OPEN_W-1:0] out_open_depth
);

  logic               s1_valid_r;
  logic [7:0]         s1_char_r;
  logic               out_valid_r;
  result_t            res_r;
  esc_t               esc_r;
  esc_t               esc_nxt;
  logic               adv;
  stack_op_t          op;
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_nxt;
  kind_t              top_kind;
  result_t            res;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char_r <= in_char_in;
    end
  end

  snt_step u_step (
    .ch        (s1_char_r),
    .depth     (depth),
    .top_kind  (top_kind),
    .esc       (esc_r),
    .op        (op),
    .depth_nxt (depth_nxt),
    .esc_nxt   (esc_nxt),
    .res       (res)
  );

  snt_stack u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .op        (op),
    .depth_nxt (depth_nxt),
    .depth     (depth),
    .top_kind  (top_kind)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r       <= ESC_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) esc_r <= esc_nxt;
      if (!out_valid_r || !out_stall) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_keep_char      = res_r.keep;
  assign out_statement_done = res_r.done;
  assign out_nesting_error  = res_r.err;
  assign out_open_depth     = res_r.open_depth;

  a_err_clears : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.err |-> !res_r.keep && !res_r.done && res_r.open_depth == '0)
    else $error("overflow result not cleared");

  a_done_drops : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done |-> !res_r.keep)
    else $error("statement end kept its newline");

  a_depth_bound : assert property (@(posedge clk) disable iff (!rst_n)
    depth <= DEPTH_W'(NEST_DEPTH))
    else $error("stack depth beyond capacity");

  a_accept_held : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted item lost in input register");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(res_r))
    else $error("stalled result changed");

endmodule

>>> dv/statement_nesting_tracker_tb.sv
// ----------------------------------------------------------------------------
// statement_nesting_tracker_tb
// Self-checking bench for the statement nesting tracker. A short directed
// stream covers the bracket kinds, escapes, stray closers and statement ends.
// It is followed by random statements with nested procedures, strings and hex
// strings, deep runs that can overflow the stack, and noise. Every result item is
// checked against a local model of the bracket stack. Both sides idle at
// random, with one long result hold-off and one drain pause.
// ----------------------------------------------------------------------------
module statement_nesting_tracker_tb;
  import snt_pkg::*;

  localparam int         TARGET_ITEMS = 850;
  localparam int         TAIL_ITEMS   = 100;
  localparam int         PAUSE_AT     = 450;
  localparam int         HOLD_AT      = 300;
  localparam int         LONG_HOLD    = 80;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_DIGIT0    = 8'h30;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_char_in;
  logic              out_valid;
  logic              out_stall;
  logic              out_keep_char;
  logic              out_statement_done;
  logic              out_nesting_error;
  logic [OPEN_W-1:0] out_open_depth;

  statement_nesting_tracker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_in         (in_char_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_keep_char      (out_keep_char),
    .out_statement_done (out_statement_done),
    .out_nesting_error  (out_nesting_error),
    .out_open_depth     (out_open_depth)
  );

  // local copy of the tracker state
  kind_t   open_stack [NEST_DEPTH];
  int      open_count;
  esc_t    escape_state;

  logic [7:0] char_q [$];
  result_t    expected_q [$];
  result_t    want;

  int  cycle_count;
  int  failures;
  int  n_driven;
  int  n_accepted;
  int  n_results;
  int  n_statements;
  int  n_overflows;
  int  deepest;
  int  in_gap;
  int  out_gap;
  int  hold_cnt;
  bit  in_taken;
  bit  drain_wait;
  bit  long_hold_done;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit push_kind(input kind_t k);
    if (open_count >= NEST_DEPTH) begin
      open_count   = 0;
      escape_state = ESC_NONE;
      return 1'b0;
    end
    open_stack[open_count] = k;
    open_count++;
    return 1'b1;
  endfunction

  function automatic bit opener(input logic [7:0] ch, output kind_t k);
    k = KIND_PROC;
    case (ch)
      CH_LBRACE: k = KIND_PROC;
      CH_LPAREN: k = KIND_STR;
      CH_LANGLE: k = KIND_HEX;
      default:   return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic result_t track_char(input logic [7:0] ch);
    result_t res;
    logic    keep;
    logic    done;
    logic    err;
    kind_t   k;
    kind_t   top;
    keep = 1'b1;
    done = 1'b0;
    err  = 1'b0;
    if (escape_state == ESC_STR) begin
      escape_state = ESC_NONE;
    end else if (escape_state == ESC_TOP) begin
      escape_state = ESC_NONE;
      if (ch == CH_NL && open_count == 0) begin
        keep = 1'b0;
        done = 1'b1;
      end
    end else if (open_count > 0) begin
      top          = open_stack[open_count-1];
      escape_state = ESC_NONE;
      if (top == KIND_PROC) begin
        if (ch == CH_RBRACE) open_count--;
        else if (opener(ch, k)) err = !push_kind(k);
      end else if (top == KIND_STR) begin
        if (ch == CH_RPAREN) open_count--;
        else if (ch == CH_LPAREN) err = !push_kind(KIND_STR);
        else if (ch == CH_BSLASH) escape_state = ESC_STR;
      end else if (ch == CH_RANGLE) begin
        open_count--;
      end
    end else begin
      escape_state = ESC_NONE;
      if (opener(ch, k)) err = !push_kind(k);
      else if (ch == CH_BSLASH) escape_state = ESC_TOP;
      else if (ch == CH_NL) begin
        keep = 1'b0;
        done = 1'b1;
      end
    end
    if (err) begin
      keep = 1'b0;
      done = 1'b0;
    end
    res.keep       = keep;
    res.done       = done;
    res.err        = err;
    res.open_depth = OPEN_W'(open_count);
    return res;
  endfunction

  function automatic logic [7:0] filler_char();
    case ($urandom_range(0, 9))
      0:       return CH_NL;
      1:       return CH_SPACE;
      default: return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 11))
      0:       return CH_LBRACE;
      1:       return CH_LPAREN;
      2:       return CH_LANGLE;
      3:       return CH_RBRACE;
      4:       return CH_RPAREN;
      5:       return CH_RANGLE;
      6:       return CH_BSLASH;
      7:       return CH_NL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_group(input int lvl, input kind_t k);
    int    n;
    kind_t sub;
    n = $urandom_range(0, 4);
    case (k)
      KIND_PROC: begin
        char_q.push_back(CH_LBRACE);
        repeat (n) begin
          if (lvl > 0 && $urandom_range(0, 2) == 0) begin
            sub = kind_t'($urandom_range(0, 2));
            add_group(lvl - 1, sub);
          end else if ($urandom_range(0, 7) == 0) begin
            char_q.push_back(CH_BSLASH);
          end else begin
            char_q.push_back(filler_char());
          end
        end
        char_q.push_back(CH_RBRACE);
      end
      KIND_STR: begin
        char_q.push_back(CH_LPAREN);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: begin
              if (lvl > 0) add_group(lvl - 1, KIND_STR);
              else char_q.push_back(filler_char());
            end
            1: begin
              char_q.push_back(CH_BSLASH);
              char_q.push_back(noise_char());
            end
            default: char_q.push_back(filler_char());
          endcase
        end
        char_q.push_back(CH_RPAREN);
      end
      default: begin
        char_q.push_back(CH_LANGLE);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0:       char_q.push_back(CH_LBRACE);
            1:       char_q.push_back(CH_LPAREN);
            2:       char_q.push_back(CH_NL);
            default: char_q.push_back(8'($urandom_range(CH_DIGIT0, CH_DIGIT0 + 9)));
          endcase
        end
        char_q.push_back(CH_RANGLE);
      end
    endcase
  endtask

  task automatic build_stream();
    logic [7:0] directed [25];
    int         n;
    bit         str_run;
    kind_t      k;
    directed = '{8'h00, 8'hFF, CH_LOWER_A, CH_RBRACE, CH_RPAREN, CH_RANGLE, CH_NL,
                 CH_LBRACE, CH_LPAREN, CH_BSLASH, CH_NL, CH_RPAREN, CH_LANGLE,
                 CH_LBRACE, CH_RANGLE, CH_NL, CH_RBRACE, CH_BSLASH, CH_LBRACE,
                 CH_BSLASH, CH_NL, CH_LPAREN, CH_LPAREN, CH_RPAREN, CH_RPAREN};
    foreach (directed[i]) char_q.push_back(directed[i]);
    char_q.push_back(CH_NL);
    while (char_q.size() < TARGET_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1) == 0) begin
              char_q.push_back(filler_char());
            end else begin
              k = kind_t'($urandom_range(0, 2));
              add_group($urandom_range(0, 3), k);
            end
          end
          char_q.push_back(CH_NL);
        end
        6, 7: begin
          repeat ($urandom_range(1, 8)) char_q.push_back(noise_char());
        end
        8: begin
          // deep run, often past the stack capacity
          n       = $urandom_range(NEST_DEPTH - 3, NEST_DEPTH + 2);
          str_run = 1'($urandom_range(0, 1));
          repeat (n) char_q.push_back(str_run ? CH_LPAREN : CH_LBRACE);
          char_q.push_back(filler_char());
          repeat (n) char_q.push_back(str_run ? CH_RPAREN : CH_RBRACE);
          char_q.push_back(CH_NL);
        end
        default: begin
          char_q.push_back(CH_BSLASH);
          char_q.push_back(noise_char());
        end
      endcase
    end
  endtask

  function automatic bit quiet_phase();
    return ((cycle_count / 150) % 3 == 2) || (char_q.size() < TAIL_ITEMS);
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_valid && !in_taken)) begin
        in_taken = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (drain_wait) begin
          in_valid <= 1'b0;
          if (expected_q.size() == 0) drain_wait = 1'b0;
        end else if (char_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet_phase() && $urandom_range(0, 4) == 0) begin
          in_gap = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          in_char_in <= char_q.pop_front();
          n_driven++;
          if (n_driven == PAUSE_AT) drain_wait = 1'b1;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!long_hold_done && n_results >= HOLD_AT) begin
        out_stall <= 1'b1;
        hold_cnt++;
        if (hold_cnt == LONG_HOLD) long_hold_done = 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet_phase() && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_valid && !in_stall) begin
      expected_q.push_back(track_char(in_char_in));
      in_taken = 1'b1;
      n_accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected");
        failures++;
      end else begin
        want = expected_q.pop_front();
        if (out_keep_char !== want.keep) begin
          $error("keep_char: expected %0d, got %0d", want.keep, out_keep_char);
          failures++;
        end
        if (out_statement_done !== want.done) begin
          $error("statement_done: expected %0d, got %0d", want.done, out_statement_done);
          failures++;
        end
        if (out_nesting_error !== want.err) begin
          $error("nesting_error: expected %0d, got %0d", want.err, out_nesting_error);
          failures++;
        end
        if (out_open_depth !== want.open_depth) begin
          $error("open_depth: expected %0d, got %0d", want.open_depth, out_open_depth);
          failures++;
        end
        if (want.done) n_statements++;
        if (want.err) n_overflows++;
        if (int'(want.open_depth) > deepest) deepest = int'(want.open_depth);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_in   = 8'h00;
    out_stall    = 1'b0;
    open_count   = 0;
    escape_state = ESC_NONE;
    foreach (open_stack[i]) open_stack[i] = KIND_PROC;
    build_stream();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (char_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d characters checked, %0d statements closed, %0d overflows",
             n_accepted, n_statements, n_overflows);
    $display("deepest nesting seen %0d of %0d", deepest, NEST_DEPTH);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/snt_pkg.sv
design/snt_stack.sv
design/snt_step.sv
design/statement_nesting_tracker.sv
dv/statement_nesting_tracker_tb.sv
